// File: src/nearest_center_search_defines.svh
// assertion macros used by the checker
`ifndef NEAREST_CENTER_SEARCH_DEFINES_SVH
`define NEAREST_CENTER_SEARCH_DEFINES_SVH

// property that holds in the same cycle as its trigger
`define NCS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// property that holds in the cycle after its trigger
`define NCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/ncs_pkg.sv
package ncs_pkg;

    localparam int COORD_W    = 24;
    localparam int DIFF_W     = 25;
    localparam int SQ_W       = 49;
    localparam int DSQ_W      = 50;
    localparam int INDEX_W    = 10;
    localparam int SCAN_W     = 11;
    localparam int DIST_W     = 25;
    localparam int ROOT_STEPS = 25;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 11;

    localparam int TABLE_DEPTH_DEF = 1024;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_INDEX = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_INDEX   = 8'd1;

    localparam logic [SCAN_W-1:0] END_INDEX_RESET = 11'd1024;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [DSQ_W-1:0] ROOT_BIT_INIT = DSQ_W'(1) << (2 * (ROOT_STEPS - 1));
    localparam logic [DIST_W-1:0] DIST_NO_MATCH = '1;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_point;

    typedef struct packed {
        logic              valid;
        logic [SCAN_W-1:0] idx;
    } t_dist_tag;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ROOT
    } t_state;

endpackage

// File: src/ncs_dist.sv
module ncs_dist (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_flush,
    input  logic                      i_valid,
    input  logic [ncs_pkg::SCAN_W-1:0] i_idx,
    input  ncs_pkg::t_point           i_center,
    input  ncs_pkg::t_point           i_target,
    output ncs_pkg::t_dist_tag        o_tag,
    output logic [ncs_pkg::DSQ_W-1:0] o_dist_sq,
    output logic                      o_pending
);
    import ncs_pkg::*;

    logic                     r_v1, r_v2, r_v3;
    logic [SCAN_W-1:0]        r_idx1, r_idx2, r_idx3;
    logic signed [DIFF_W-1:0] r_dx, r_dy, r_dz;
    logic [SQ_W-1:0]          r_sqx, r_sqy, r_sqz;
    logic [DSQ_W-1:0]         r_sum;

    logic signed [2*DIFF_W-1:0] prod_x, prod_y, prod_z;

    assign prod_x = r_dx * r_dx;
    assign prod_y = r_dy * r_dy;
    assign prod_z = r_dz * r_dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid & ~i_flush;
            r_v2 <= r_v1 & ~i_flush;
            r_v3 <= r_v2 & ~i_flush;
        end
    end

    // difference, square, sum
    always_ff @(posedge i_clk) begin
        r_idx1 <= i_idx;
        r_dx   <= DIFF_W'(i_center.x) - DIFF_W'(i_target.x);
        r_dy   <= DIFF_W'(i_center.y) - DIFF_W'(i_target.y);
        r_dz   <= DIFF_W'(i_center.z) - DIFF_W'(i_target.z);
        r_idx2 <= r_idx1;
        r_sqx  <= prod_x[SQ_W-1:0];
        r_sqy  <= prod_y[SQ_W-1:0];
        r_sqz  <= prod_z[SQ_W-1:0];
        r_idx3 <= r_idx2;
        r_sum  <= DSQ_W'(r_sqx) + DSQ_W'(r_sqy) + DSQ_W'(r_sqz);
    end

    assign o_tag     = '{valid: r_v3, idx: r_idx3};
    assign o_dist_sq = r_sum;
    assign o_pending = r_v1 | r_v2 | r_v3;

endmodule

// File: src/ncs_isqrt.sv
module ncs_isqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [ncs_pkg::DSQ_W-1:0]  i_value,
    output logic                       o_done,
    output logic [ncs_pkg::DIST_W-1:0] o_root
);
    import ncs_pkg::*;

    localparam int STEP_W = $clog2(ROOT_STEPS);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DSQ_W-1:0]  r_rem;
    logic [DSQ_W-1:0]  r_res;
    logic [DSQ_W-1:0]  r_bit;

    logic [DSQ_W-1:0] trial;
    logic             fits;
    logic [DSQ_W-1:0] n_rem;
    logic [DSQ_W-1:0] n_res;

    // one result bit per step
    always_comb begin
        trial = r_res + r_bit;
        fits  = r_rem >= trial;
        n_rem = fits ? r_rem - trial : r_rem;
        n_res = fits ? (r_res >> 1) + r_bit : r_res >> 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(ROOT_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_value;
            r_res <= '0;
            r_bit <= ROOT_BIT_INIT;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_res <= n_res;
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[DIST_W-1:0];

endmodule

// File: src/nearest_center_search.sv
// Nearest center search. A load word (cmd 0) writes one center into the table and leaves
// busy low; entries must be loaded before a query reaches them. A query word (cmd 1) raises
// busy, scans one table entry per cycle from max(start_index, first_index) upward, below
// end_index and the table depth, stops at the first entry whose squared distance does not
// strictly fall, then takes the square root of the best one, one result bit per step over
// 25 steps; if no entry was scanned it reports no match. The table has a single read port,
// the root unit is iterative, and a new word is taken only once busy is low again. A query
// result appears for exactly one cycle on o_done together with busy falling; the receiver
// cannot stall, so it must take the word in that cycle. Configuration writes are always
// ready and are to be made while busy is low.
module nearest_center_search #(
    parameter int TABLE_DEPTH = ncs_pkg::TABLE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_cmd,
    input  logic [ncs_pkg::INDEX_W-1:0]     i_entry_index,
    input  logic signed [ncs_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [ncs_pkg::COORD_W-1:0] i_point_y,
    input  logic signed [ncs_pkg::COORD_W-1:0] i_point_z,
    input  logic [ncs_pkg::INDEX_W-1:0]     i_start_index,
    output logic                            o_done,
    output logic                            o_match_found,
    output logic [ncs_pkg::INDEX_W-1:0]     o_closest_index,
    output logic [ncs_pkg::DIST_W-1:0]      o_distance,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ncs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ncs_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import ncs_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    t_state r_state, n_state;

    logic [INDEX_W-1:0] r_first_index;
    logic [SCAN_W-1:0]  r_end_index;

    t_point             r_mem [TABLE_DEPTH];
    t_point             r_target;
    t_point             r_rd_data;
    logic               r_rd_valid;
    logic [SCAN_W-1:0]  r_rd_idx;
    logic [SCAN_W-1:0]  r_idx;
    logic [SCAN_W-1:0]  r_stop;
    logic               r_halt;
    logic               r_have;
    logic [DSQ_W-1:0]   r_best;
    logic [INDEX_W-1:0] r_best_idx;

    logic               r_done;
    logic               r_match;
    logic [INDEX_W-1:0] r_cidx;
    logic [DIST_W-1:0]  r_dist;

    t_dist_tag          tag;
    logic [DSQ_W-1:0]   dist_sq;
    logic               dist_pending;
    logic               root_done;
    logic [DIST_W-1:0]  root;

    logic               accept;
    logic               load_ok;
    logic [INDEX_W-1:0] q_start;
    logic [SCAN_W-1:0]  q_stop;
    logic               better;
    logic               brk;
    logic               issue;
    logic               scan_done;
    logic               root_start;
    logic               emit_none;
    logic               emit_root;

    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept      = start & ~busy;
    assign load_ok     = {22'd0, i_entry_index} < 32'(TABLE_DEPTH);
    assign q_start     = (i_start_index < r_first_index) ? r_first_index : i_start_index;
    assign q_stop      = ({21'd0, r_end_index} < 32'(TABLE_DEPTH)) ? r_end_index
                                                                   : SCAN_W'(TABLE_DEPTH);

    // compare the word leaving the distance pipe with the running best
    assign better    = ~r_have | (dist_sq < r_best);
    assign brk       = tag.valid & ~better;
    assign issue     = (r_state == ST_SCAN) & ~r_halt & ~brk & (r_idx < r_stop);
    assign scan_done = ~r_rd_valid & ~dist_pending & (r_halt | (r_idx >= r_stop));

    always_comb begin
        n_state    = r_state;
        root_start = 1'b0;
        emit_none  = 1'b0;
        emit_root  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && i_cmd == CMD_QUERY) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    if (r_have) begin
                        n_state    = ST_ROOT;
                        root_start = 1'b1;
                    end else begin
                        n_state   = ST_IDLE;
                        emit_none = 1'b1;
                    end
                end
            end
            ST_ROOT: begin
                if (root_done) begin
                    n_state   = ST_IDLE;
                    emit_root = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_index <= '0;
            r_end_index   <= END_INDEX_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_FIRST_INDEX: r_first_index <= i_cfg_data[INDEX_W-1:0];
                CFG_END_INDEX:   r_end_index   <= i_cfg_data[SCAN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // center table
    always_ff @(posedge i_clk) begin
        if (accept && i_cmd == CMD_LOAD && load_ok) begin
            r_mem[AW'(i_entry_index)] <= t_point'{i_point_x, i_point_y, i_point_z};
        end
        if (issue) begin
            r_rd_data <= r_mem[AW'(r_idx)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
            r_halt     <= 1'b0;
            r_have     <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_rd_valid <= issue;
            r_done     <= emit_none | emit_root;
            if (accept && i_cmd == CMD_QUERY) begin
                r_halt <= 1'b0;
                r_have <= 1'b0;
            end else begin
                if (brk) begin
                    r_halt <= 1'b1;
                end
                if (tag.valid && better && r_state == ST_SCAN) begin
                    r_have <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_cmd == CMD_QUERY) begin
            r_target <= t_point'{i_point_x, i_point_y, i_point_z};
            r_idx    <= {1'b0, q_start};
            r_stop   <= q_stop;
        end else if (issue) begin
            r_idx <= r_idx + SCAN_W'(1);
        end
        r_rd_idx <= r_idx;
        if (tag.valid && better && r_state == ST_SCAN) begin
            r_best     <= dist_sq;
            r_best_idx <= tag.idx[INDEX_W-1:0];
        end
        if (emit_none) begin
            r_match <= 1'b0;
            r_cidx  <= '0;
            r_dist  <= DIST_NO_MATCH;
        end else if (emit_root) begin
            r_match <= 1'b1;
            r_cidx  <= r_best_idx;
            r_dist  <= root;
        end
    end

    ncs_dist u_dist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_flush   (brk),
        .i_valid   (r_rd_valid),
        .i_idx     (r_rd_idx),
        .i_center  (r_rd_data),
        .i_target  (r_target),
        .o_tag     (tag),
        .o_dist_sq (dist_sq),
        .o_pending (dist_pending)
    );

    ncs_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (root_start),
        .i_value (r_best),
        .o_done  (root_done),
        .o_root  (root)
    );

    assign o_done          = r_done;
    assign o_match_found   = r_match;
    assign o_closest_index = r_cidx;
    assign o_distance      = r_dist;

endmodule

// File: src/nearest_center_search_chk.sv
`include "nearest_center_search_defines.svh"

module nearest_center_search_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            start,
    input logic                            busy,
    input logic                            i_cmd,
    input logic                            o_done,
    input logic                            o_match_found,
    input logic [ncs_pkg::INDEX_W-1:0]     o_closest_index,
    input logic [ncs_pkg::DIST_W-1:0]      o_distance
);
    import ncs_pkg::*;

    `NCS_ASSERT_SAME(a_no_match_word, o_done && !o_match_found, o_closest_index == '0 && o_distance == DIST_NO_MATCH, "no-match word carries wrong fields")
    `NCS_ASSERT_NEXT(a_query_busy, start && !busy && i_cmd == CMD_QUERY, busy, "query word did not raise busy")
    `NCS_ASSERT_NEXT(a_load_quiet, start && !busy && i_cmd == CMD_LOAD, !busy && !o_done, "load word caused busy or a result")
    `NCS_ASSERT_SAME(a_busy_ends_done, $fell(busy) && $past(i_rst_n), o_done, "busy fell without a result")

endmodule

bind nearest_center_search nearest_center_search_chk u_chk (.*);

// File: dv/nearest_center_search_tb.sv
module nearest_center_search_tb;
    import ncs_pkg::*;

    localparam int DEPTH         = TABLE_DEPTH_DEF;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 3_000_000;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 8'hFF;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;

    typedef struct {
        logic               cmd;
        logic [INDEX_W-1:0] entry;
        t_point             pt;
        logic [INDEX_W-1:0] start_idx;
    } t_word;

    typedef struct {
        logic               found;
        logic [INDEX_W-1:0] closest;
        logic [DIST_W-1:0]  distance;
    } t_reply;

    logic                      i_clk           = 1'b0;
    logic                      i_rst_n         = 1'b0;
    logic                      start           = 1'b0;
    logic                      busy;
    logic                      i_cmd           = CMD_LOAD;
    logic [INDEX_W-1:0]        i_entry_index   = '0;
    logic signed [COORD_W-1:0] i_point_x       = '0;
    logic signed [COORD_W-1:0] i_point_y       = '0;
    logic signed [COORD_W-1:0] i_point_z       = '0;
    logic [INDEX_W-1:0]        i_start_index   = '0;
    logic                      o_done;
    logic                      o_match_found;
    logic [INDEX_W-1:0]        o_closest_index;
    logic [DIST_W-1:0]         o_distance;
    logic                      i_cfg_valid     = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index     = '0;
    logic [CFG_DATA_W-1:0]     i_cfg_data      = '0;

    nearest_center_search uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cmd           (i_cmd),
        .i_entry_index   (i_entry_index),
        .i_point_x       (i_point_x),
        .i_point_y       (i_point_y),
        .i_point_z       (i_point_z),
        .i_start_index   (i_start_index),
        .o_done          (o_done),
        .o_match_found   (o_match_found),
        .o_closest_index (o_closest_index),
        .o_distance      (o_distance),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    t_point             center_mem [DEPTH];
    logic [INDEX_W-1:0] cfg_first = '0;
    logic [SCAN_W-1:0]  cfg_end   = END_INDEX_RESET;

    t_word  pending_words[$];
    t_reply awaited_replies[$];
    t_word  cur_word;
    logic   holding  = 1'b0;
    logic   gapped   = 1'b0;
    logic   no_idle  = 1'b0;
    int     gap_left = 0;

    t_point ramp_target;
    int     ramp_dx, ramp_dy, ramp_dz;
    int     ramp_pivot;
    int     win_lo, win_hi;

    int mismatches    = 0;
    int loads_done    = 0;
    int queries_done  = 0;
    int empty_results = 0;
    int longest_scan  = 0;
    int replies_seen  = 0;
    int cycle_count   = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [63:0] dist_sq(input t_point a, input t_point b);
        longint dx, dy, dz;
        dx = longint'($signed(a.x)) - longint'($signed(b.x));
        dy = longint'($signed(a.y)) - longint'($signed(b.y));
        dz = longint'($signed(a.z)) - longint'($signed(b.z));
        return 64'(dx * dx + dy * dy + dz * dz);
    endfunction

    function automatic logic [63:0] int_root(input logic [63:0] v);
        logic [63:0] rem, res, one;
        rem = v;
        res = '0;
        one = 64'd1 << 62;
        while (one > rem) one = one >> 2;
        while (one != 0) begin
            if (rem >= res + one) begin
                rem = rem - (res + one);
                res = (res >> 1) + one;
            end else begin
                res = res >> 1;
            end
            one = one >> 2;
        end
        return res;
    endfunction

    function automatic t_reply predict_search(input t_point target,
                                              input logic [INDEX_W-1:0] from,
                                              output int scanned);
        t_reply      r;
        int          lo, hi, i;
        logic [63:0] d2, best;
        logic        have, stopped;
        lo = from;
        if (lo < cfg_first) lo = cfg_first;
        hi = cfg_end;
        if (hi > DEPTH) hi = DEPTH;
        have       = 1'b0;
        stopped    = 1'b0;
        best       = '0;
        scanned    = 0;
        r.found    = 1'b0;
        r.closest  = '0;
        r.distance = DIST_NO_MATCH;
        for (i = lo; i < hi && !stopped; i++) begin
            d2 = dist_sq(center_mem[i], target);
            scanned++;
            if (!have || d2 < best) begin
                have      = 1'b1;
                best      = d2;
                r.closest = INDEX_W'(i);
            end else begin
                stopped = 1'b1;
            end
        end
        if (have) begin
            r.found    = 1'b1;
            r.distance = DIST_W'(int_root(best));
        end
        return r;
    endfunction

    // driver: one word per start/busy handshake, random gaps in between
    always @(posedge i_clk) begin : driver
        t_reply r;
        int     scanned;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                holding = 1'b0;
                if (cur_word.cmd == CMD_LOAD) begin
                    center_mem[cur_word.entry] = cur_word.pt;
                    loads_done++;
                end else begin
                    r = predict_search(cur_word.pt, cur_word.start_idx, scanned);
                    awaited_replies.push_back(r);
                    queries_done++;
                    if (!r.found) empty_results++;
                    if (scanned > longest_scan) longest_scan = scanned;
                end
            end
            if (!holding) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (pending_words.size() == 0) begin
                    start <= 1'b0;
                end else if (!no_idle && !gapped && $urandom_range(0, 3) == 0) begin
                    gap_left = $urandom_range(0, 16);
                    gapped   = 1'b1;
                    start <= 1'b0;
                end else begin
                    cur_word = pending_words.pop_front();
                    holding  = 1'b1;
                    gapped   = 1'b0;
                    start         <= 1'b1;
                    i_cmd         <= cur_word.cmd;
                    i_entry_index <= cur_word.entry;
                    i_point_x     <= cur_word.pt.x;
                    i_point_y     <= cur_word.pt.y;
                    i_point_z     <= cur_word.pt.z;
                    i_start_index <= cur_word.start_idx;
                end
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_reply want;
        if (i_rst_n && o_done) begin
            replies_seen++;
            if (awaited_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: found %0d index %0d distance %0d",
                             o_match_found, o_closest_index, o_distance);
            end else begin
                want = awaited_replies.pop_front();
                if (o_match_found !== want.found || o_closest_index !== want.closest ||
                    o_distance !== want.distance) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                                 want.found, want.closest, want.distance,
                                 o_match_found, o_closest_index, o_distance);
                end
            end
        end
    end

    function automatic t_point pt3(input logic signed [COORD_W-1:0] x,
                                   input logic signed [COORD_W-1:0] y,
                                   input logic signed [COORD_W-1:0] z);
        t_point p;
        p.x = x;
        p.y = y;
        p.z = z;
        return p;
    endfunction

    function automatic t_point rand_point();
        return pt3(COORD_W'($urandom()), COORD_W'($urandom()), COORD_W'($urandom()));
    endfunction

    function automatic int rand_coord(input int bits);
        return int'($urandom_range(0, (1 << (bits + 1)) - 1)) - (1 << bits);
    endfunction

    function automatic int rand_step();
        int k;
        k = $urandom_range(0, 14);
        return int'($urandom_range(0, 2 << k)) - (1 << k);
    endfunction

    function automatic logic [INDEX_W-1:0] pick_start();
        int r;
        r = $urandom_range(0, 9);
        if (win_hi <= win_lo || r == 9) return INDEX_W'($urandom());
        if (r == 6) return INDEX_W'($urandom_range(0, win_lo));
        if (r >= 7) return INDEX_W'(win_lo);
        return INDEX_W'($urandom_range(win_lo, win_hi - 1));
    endfunction

    function automatic void queue_word(input logic cmd, input logic [INDEX_W-1:0] entry,
                                       input t_point pt, input logic [INDEX_W-1:0] st);
        t_word w;
        w.cmd       = cmd;
        w.entry     = entry;
        w.pt        = pt;
        w.start_idx = st;
        pending_words.push_back(w);
    endfunction

    // centers approach the ramp target up to the pivot and recede after it
    function automatic void lay_ramp(input int lo, input int hi);
        int     i, steps;
        t_point p;
        ramp_target = pt3(COORD_W'(rand_coord(21)), COORD_W'(rand_coord(21)),
                          COORD_W'(rand_coord(21)));
        ramp_dx     = rand_step();
        ramp_dy     = rand_step();
        ramp_dz     = rand_step();
        ramp_pivot  = $urandom_range(lo, hi - 1);
        for (i = lo; i < hi; i++) begin
            steps = (i > ramp_pivot) ? i - ramp_pivot : ramp_pivot - i;
            p.x = COORD_W'(int'(ramp_target.x) + ramp_dx * steps);
            p.y = COORD_W'(int'(ramp_target.y) + ramp_dy * steps);
            p.z = COORD_W'(int'(ramp_target.z) + ramp_dz * steps);
            queue_word(CMD_LOAD, INDEX_W'(i), p, INDEX_W'($urandom()));
        end
    endfunction

    task automatic settle();
        while (pending_words.size() != 0 || holding || awaited_replies.size() != 0 || busy)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_FIRST_INDEX) cfg_first = data[INDEX_W-1:0];
        else if (idx == CFG_END_INDEX) cfg_end = data;
    endtask

    task automatic random_phase(input logic [CFG_DATA_W-1:0] first_data,
                                input logic [CFG_DATA_W-1:0] end_data,
                                input int n_mixed);
        int     n, r;
        t_point near;
        settle();
        if ($urandom_range(0, 1) == 1) write_reg(CFG_SPARE_HI, CFG_DATA_W'($urandom()));
        write_reg(CFG_FIRST_INDEX, first_data);
        write_reg(CFG_END_INDEX, end_data);
        win_lo = first_data[INDEX_W-1:0];
        win_hi = (end_data > DEPTH) ? DEPTH : end_data;
        if (win_hi > win_lo) lay_ramp(win_lo, win_hi);
        for (n = 0; n < n_mixed; n++) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                near.x = COORD_W'(int'(ramp_target.x) + int'($urandom_range(0, 64)) - 32);
                near.y = COORD_W'(int'(ramp_target.y) + int'($urandom_range(0, 64)) - 32);
                near.z = COORD_W'(int'(ramp_target.z) + int'($urandom_range(0, 64)) - 32);
                if ($urandom_range(0, 3) == 0) near = ramp_target;
                queue_word(CMD_QUERY, INDEX_W'($urandom()), near, pick_start());
            end else if (r < 62) begin
                queue_word(CMD_QUERY, INDEX_W'($urandom()), rand_point(), pick_start());
            end else if (r < 77 && win_hi > win_lo) begin
                queue_word(CMD_LOAD, INDEX_W'($urandom_range(win_lo, win_hi - 1)),
                           rand_point(), INDEX_W'($urandom()));
            end else if (r < 99 || win_hi <= win_lo || win_hi - win_lo > 64) begin
                queue_word(CMD_LOAD, INDEX_W'($urandom()), rand_point(), INDEX_W'($urandom()));
            end else begin
                lay_ramp(win_lo, win_hi);
            end
        end
    endtask

    initial begin : stimulus
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // spare register indexes, then a four-entry window
        write_reg(CFG_SPARE_LO, 11'h7FF);
        write_reg(CFG_SPARE_HI, 11'h555);
        write_reg(CFG_FIRST_INDEX, 11'd0);
        write_reg(CFG_END_INDEX, 11'd4);
        queue_word(CMD_LOAD, 10'd0, pt3(0, 0, 0), 10'h3FF);
        queue_word(CMD_LOAD, 10'd1, pt3(0, 0, 0), 10'd0);
        queue_word(CMD_LOAD, 10'd2, pt3(COORD_MAX, COORD_MAX, COORD_MAX), 10'd0);
        queue_word(CMD_LOAD, 10'd3, pt3(COORD_MIN, COORD_MIN, COORD_MIN), 10'd0);
        // largest distance, tie stops the scan, improve then stop, empty start
        queue_word(CMD_QUERY, 10'h3FF, pt3(COORD_MAX, COORD_MAX, COORD_MAX), 10'd3);
        queue_word(CMD_QUERY, 10'd0, pt3(0, 0, 0), 10'd0);
        queue_word(CMD_QUERY, 10'd0, pt3(COORD_MIN, COORD_MIN, COORD_MIN), 10'd1);
        queue_word(CMD_QUERY, 10'd0, pt3(COORD_MAX, COORD_MAX, COORD_MAX), 10'd1);
        queue_word(CMD_QUERY, 10'd0, pt3(0, 0, 0), 10'h3FF);
        queue_word(CMD_QUERY, 10'd0, pt3(COORD_MAX, COORD_MIN, 0), 10'd0);
        queue_word(CMD_QUERY, 10'd0, pt3(COORD_MIN, COORD_MIN, COORD_MIN), 10'd2);

        // empty window
        settle();
        write_reg(CFG_END_INDEX, 11'd0);
        queue_word(CMD_QUERY, 10'd0, pt3(0, 0, 0), 10'd0);

        // start raised to first index, unused data bit set
        settle();
        write_reg(CFG_FIRST_INDEX, 11'h402);
        write_reg(CFG_END_INDEX, 11'd4);
        queue_word(CMD_QUERY, 10'd0, pt3(COORD_MAX, COORD_MAX, COORD_MAX), 10'd0);
        queue_word(CMD_QUERY, 10'd0, pt3(COORD_MIN, COORD_MIN, COORD_MIN), 10'd0);
        queue_word(CMD_QUERY, 10'd0, pt3(0, 0, 0), 10'd3);

        settle();
        write_reg(CFG_FIRST_INDEX, 11'd4);
        queue_word(CMD_QUERY, 10'd0, pt3(0, 0, 0), 10'd3);

        settle();
        write_reg(CFG_FIRST_INDEX, 11'd3);
        write_reg(CFG_END_INDEX, 11'd2);
        queue_word(CMD_QUERY, 10'd0, pt3(0, 0, 0), 10'd0);

        random_phase(11'd0, 11'd40, 60);
        random_phase(11'd896, 11'd2047, 30);
        random_phase(11'd1023, 11'd1024, 15);
        random_phase(11'h400 | 11'd100, 11'd148, 50);
        random_phase(11'd5, 11'd0, 15);
        settle();
        no_idle = 1'b1;
        random_phase(11'd8, 11'd48, 50);

        settle();
        mismatches += awaited_replies.size();
        $display("sent %0d loads and %0d queries across several index windows", loads_done,
                 queries_done);
        $display("checked %0d results, %0d empty, longest scan %0d entries, %0d mismatches",
                 replies_seen, empty_results, longest_scan, mismatches);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+src
src/ncs_pkg.sv
src/ncs_dist.sv
src/ncs_isqrt.sv
src/nearest_center_search.sv
src/nearest_center_search_chk.sv
dv/nearest_center_search_tb.sv
